>>> design/shbs_pkg.sv
// Shared types, constants and round functions for the SHA-256 byte stream hasher.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package shbs_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = 2;

   // command that the front end hands to the back end
   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       final_item;
   } cmd_type;

   localparam logic [31:0] INIT_WORDS [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_CONSTS [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [7:0] PAD_MARK = 8'h80;

   function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned s);
      rotr = (v >> s) | (v << (32 - s));
   endfunction

   function automatic logic [31:0] sig0(input logic [31:0] v);
      sig0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
   endfunction

   function automatic logic [31:0] sig1(input logic [31:0] v);
      sig1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
   endfunction

   function automatic logic [31:0] big0(input logic [31:0] v);
      big0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
   endfunction

   function automatic logic [31:0] big1(input logic [31:0] v);
      big1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
   endfunction

endpackage
`default_nettype wire

>>> design/shbs_front.sv
// Front end: accepts byte beats, drops empty non-final beats, queues commands.
// Depends on shbs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module shbs_front
   import shbs_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_has_byte,
   input  wire logic       req_final_item,
   output logic            cmd_valid,
   input  wire logic       cmd_ready,
   output cmd_type         cmd_data
);

   cmd_type                 queue_mem [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]       count_ff, count_in;
   logic                    push, pop;

   assign req_ready = (count_ff != (QUEUE_AW+1)'(QUEUE_DEPTH));
   // drop beats that neither carry a byte nor end the message
   assign push      = req_valid && req_ready && (req_has_byte || req_final_item);
   assign cmd_valid = (count_ff != '0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd_data  = queue_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_mem[wr_ptr_ff] <= '{data_byte: req_data_byte, has_byte: req_has_byte,
                                   final_item: req_final_item};
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

>>> design/shbs_core.sv
// Back end: block buffer, padding sequencer, one-round-per-cycle compressor, digest out.
// Depends on shbs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module shbs_core
   import shbs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        cmd_valid,
   output logic             cmd_ready,
   input  wire cmd_type     cmd_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_last_word
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PAD  = 3'd1;
   localparam logic [2:0] ST_COMP = 3'd2;
   localparam logic [2:0] ST_ADD  = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [31:0] chain_ff [8];
   logic [31:0] work_ff [8];
   logic [31:0] sched_ff [16];      // 16-word schedule window, shifted each round
   logic [5:0]  fill_ff, fill_in;
   logic [60:0] msg_ff, msg_in;
   logic [5:0]  round_ff, round_in;
   logic        padding_ff, padding_in;       // pad mark placed; emit digest after length
   logic        len_here_ff, len_here_in;     // length field goes in the current block
   logic        final_pend_ff, final_pend_in; // final beat closed a full block
   logic [2:0]  out_idx_ff, out_idx_in;
   logic        put_en;
   logic [7:0]  put_byte;
   logic [63:0] bit_len;
   logic [31:0] t1, t2, w_new;
   logic [31:0] w_cur;
   logic        out_done;

   assign bit_len = {msg_ff, 3'b000};
   assign w_cur   = sched_ff[0];
   assign t1 = work_ff[7] + big1(work_ff[4])
             + ((work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]))
             + ROUND_CONSTS[round_ff] + w_cur;
   assign t2 = big0(work_ff[0])
             + ((work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
                ^ (work_ff[1] & work_ff[2]));
   assign w_new = sched_ff[0] + sig0(sched_ff[1]) + sched_ff[9] + sig1(sched_ff[14]);

   assign cmd_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = (state_ff == ST_OUT);
   assign rsp_digest_word = chain_ff[out_idx_ff];
   assign rsp_word_index  = out_idx_ff;
   assign rsp_last_word   = (out_idx_ff == 3'd7);
   assign out_done        = (state_ff == ST_OUT) && rsp_ready && (out_idx_ff == 3'd7);

   always_comb begin
      put_en        = 1'b0;
      put_byte      = 8'h00;
      msg_in        = msg_ff;
      state_in      = state_ff;
      padding_in    = padding_ff;
      len_here_in   = len_here_ff;
      final_pend_in = final_pend_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               if (cmd_data.has_byte) begin
                  put_en   = 1'b1;
                  put_byte = cmd_data.data_byte;
                  msg_in   = msg_ff + 61'd1;
               end
               if (cmd_data.final_item) begin
                  state_in = ST_PAD;
               end
               // full block: compress first, pad afterwards when final
               if (cmd_data.has_byte && fill_ff == 6'd63) begin
                  state_in      = ST_COMP;
                  final_pend_in = cmd_data.final_item;
               end
            end
         end
         ST_PAD: begin
            put_en     = 1'b1;
            padding_in = 1'b1;
            if (!padding_ff) begin
               put_byte    = PAD_MARK;
               len_here_in = (fill_ff <= 6'd55);
            end else if (len_here_ff && fill_ff >= 6'd56) begin
               put_byte = bit_len[{~fill_ff[2:0], 3'b000} +: 8];
            end
            if (fill_ff == 6'd63) begin
               state_in = ST_COMP;
            end
         end
         ST_COMP: begin
            if (round_ff == 6'd63) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            if (final_pend_ff) begin
               state_in      = ST_PAD;
               final_pend_in = 1'b0;
            end else if (padding_ff) begin
               if (len_here_ff) begin
                  state_in = ST_OUT;
               end else begin
                  // mark filled the block; length goes in one more block
                  state_in    = ST_PAD;
                  len_here_in = 1'b1;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (out_done) begin
               state_in    = ST_IDLE;
               padding_in  = 1'b0;
               len_here_in = 1'b0;
               msg_in      = '0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      fill_in    = put_en ? fill_ff + 6'd1 : fill_ff;
      round_in   = (state_ff == ST_COMP) ? round_ff + 6'd1 : 6'd0;
      out_idx_in = (state_ff == ST_OUT && rsp_ready) ? out_idx_ff + 3'd1 : out_idx_ff;
   end

   // schedule window doubles as the block buffer
   always_ff @(posedge clock) begin
      if (put_en) begin
         sched_ff[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] <= put_byte;
      end else if (state_ff == ST_COMP) begin
         for (int i = 0; i < 15; i++) begin
            sched_ff[i] <= sched_ff[i+1];
         end
         sched_ff[15] <= w_new;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_COMP) begin
         work_ff[7] <= work_ff[6];
         work_ff[6] <= work_ff[5];
         work_ff[5] <= work_ff[4];
         work_ff[4] <= work_ff[3] + t1;
         work_ff[3] <= work_ff[2];
         work_ff[2] <= work_ff[1];
         work_ff[1] <= work_ff[0];
         work_ff[0] <= t1 + t2;
      end else begin
         for (int i = 0; i < 8; i++) begin
            work_ff[i] <= chain_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ff       <= '0;
         msg_ff        <= '0;
         round_ff      <= '0;
         padding_ff    <= 1'b0;
         len_here_ff   <= 1'b0;
         final_pend_ff <= 1'b0;
         out_idx_ff    <= '0;
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= INIT_WORDS[i];
         end
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         msg_ff        <= msg_in;
         round_ff      <= round_in;
         padding_ff    <= padding_in;
         len_here_ff   <= len_here_in;
         final_pend_ff <= final_pend_in;
         out_idx_ff    <= out_idx_in;
         if (state_ff == ST_ADD) begin
            for (int i = 0; i < 8; i++) begin
               chain_ff[i] <= chain_ff[i] + work_ff[i];
            end
         end else if (out_done) begin
            for (int i = 0; i < 8; i++) begin
               chain_ff[i] <= INIT_WORDS[i];
            end
         end
      end
   end

endmodule
`default_nettype wire

>>> design/sha256_byte_stream_hasher_unit.sv
// Top level of the SHA-256 byte stream hasher: front queue plus compression core.
// Depends on shbs_pkg, shbs_front, shbs_core.
`timescale 1ns / 1ps
`default_nettype none
//  channel | ports                      | beat
//  req     | req_valid / req_ready      | one message byte, flags has_byte, final_item
//  rsp     | rsp_valid / rsp_ready      | one digest word, index, last flag
//
// The core takes a byte while idle; the 64th byte of a block starts 64 rounds on
// the single shared round unit, followed by an add step.
// A final beat adds the padding bytes one a cycle, one or two compressions and
// eight digest beats. Reset is synchronous and restores the initial hash.
// The four-entry queue lets byte beats land while the core compresses or the
// digest stalls.
module sha256_byte_stream_hasher_unit
   import shbs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_has_byte,
   input  wire logic        req_final_item,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_last_word
);

   logic    cmd_valid, cmd_ready;
   cmd_type cmd_data;

   shbs_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data_byte, .req_has_byte,
      .req_final_item, .cmd_valid, .cmd_ready, .cmd_data
   );

   shbs_core u_core (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd_data, .rsp_valid, .rsp_ready,
      .rsp_digest_word, .rsp_word_index, .rsp_last_word
   );

endmodule
`default_nettype wire
